>>> rtl/core/websocket_frame_encoder_assert.svh
// Assertion macros used by the encoder top level.
`ifndef WEBSOCKET_FRAME_ENCODER_ASSERT_SVH
`define WEBSOCKET_FRAME_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WSFE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wsfe assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WSFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("wsfe assertion failed");

`endif

>>> rtl/core/wsfe_pkg.sv
package wsfe_pkg;

	localparam int LEN_W = 63;
	localparam int KEY_W = 32;
	localparam int IDX_W = 4;

	localparam logic [7:0]       HDR_FIN       = 8'h80;
	localparam logic [6:0]       LEN_CODE_16   = 7'd126;
	localparam logic [6:0]       LEN_CODE_64   = 7'd127;
	localparam logic [LEN_W-1:0] LEN_MAX_SHORT = LEN_W'(125);
	localparam logic [LEN_W-1:0] LEN_MAX_16    = LEN_W'(16'hFFFF);

	typedef enum logic {
		ACT_START = 1'b0,
		ACT_DATA  = 1'b1
	} action_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_CTRL_LONG = 2'd1,
		ST_NO_FRAME  = 2'd2
	} status_t;

	// One result item as it leaves the block
	typedef struct packed {
		logic [7:0] data;
		logic       byte_valid;
		logic       last;
		logic       fend;
		status_t    status;
	} res_t;

	// Frame state update strobes
	typedef struct packed {
		logic open_frame;
		logic take_byte;
	} frame_cmd_t;

endpackage

>>> rtl/core/wsfe_hdr.sv
module wsfe_hdr (
	input  logic [3:0]                  opcode,
	input  logic [wsfe_pkg::LEN_W-1:0]  len,
	input  logic [wsfe_pkg::KEY_W-1:0]  key,
	input  logic                        masked,
	input  logic [wsfe_pkg::IDX_W-1:0]  idx,
	output wsfe_pkg::res_t              res
);
	import wsfe_pkg::*;

	logic             len_short;
	logic             len_16;
	logic [IDX_W-1:0] nlen;
	logic [IDX_W-1:0] last_idx;
	logic [IDX_W-1:0] j;
	logic [IDX_W-1:0] kj;
	logic [2:0]       sel;
	logic [6:0]       code7;
	logic [63:0]      len64;
	logic [7:0]       len_bytes [8];
	logic [7:0]       key_bytes [4];

	assign len64 = {1'b0, len};

	always_comb begin
		for (int b = 0; b < 8; b++) begin
			len_bytes[b] = len64[8*(7-b) +: 8];
		end
		for (int b = 0; b < 4; b++) begin
			key_bytes[b] = key[8*(3-b) +: 8];
		end
	end

	assign len_short = (len <= LEN_MAX_SHORT);
	assign len_16    = !len_short && (len <= LEN_MAX_16);
	assign nlen      = len_short ? IDX_W'(0) : (len_16 ? IDX_W'(2) : IDX_W'(8));
	assign last_idx  = IDX_W'(1) + nlen + (masked ? IDX_W'(4) : IDX_W'(0));
	assign code7     = len_short ? len[6:0] : (len_16 ? LEN_CODE_16 : LEN_CODE_64);
	assign j         = idx - IDX_W'(2);
	assign kj        = j - nlen;
	// 16-bit length sits in the low two bytes of the 64-bit big-endian view
	assign sel       = (len_16 ? 3'd6 : 3'd0) + j[2:0];

	always_comb begin
		res.byte_valid = 1'b1;
		res.status     = ST_OK;
		res.last       = (idx == last_idx);
		res.fend       = (idx == last_idx) && (len == '0);
		if (idx == IDX_W'(0)) begin
			res.data = HDR_FIN | {4'd0, opcode};
		end else if (idx == IDX_W'(1)) begin
			res.data = {masked, code7};
		end else if (j < nlen) begin
			res.data = len_bytes[sel];
		end else begin
			res.data = key_bytes[kj[1:0]];
		end
	end

endmodule

>>> rtl/core/wsfe_frame.sv
module wsfe_frame (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wsfe_pkg::frame_cmd_t        cmd,
	input  logic [wsfe_pkg::LEN_W-1:0]  len,
	input  logic [wsfe_pkg::KEY_W-1:0]  key,
	input  logic                        masked,
	input  logic [7:0]                  data_byte,
	output logic                        frame_open,
	output wsfe_pkg::res_t              res
);
	import wsfe_pkg::*;

	logic             open_q;
	logic [LEN_W-1:0] left_q;
	logic [1:0]       phase_q;
	logic [KEY_W-1:0] key_q;
	logic             masked_q;
	logic             end_byte;
	logic [7:0]       key_byte;

	// bytes_left never reaches zero while open, so the last byte is left == 1
	assign end_byte   = (left_q == LEN_W'(1));
	assign key_byte   = key_q[8*(3-phase_q) +: 8];
	assign frame_open = open_q;

	always_comb begin
		res.data       = masked_q ? (data_byte ^ key_byte) : data_byte;
		res.byte_valid = 1'b1;
		res.last       = 1'b1;
		res.fend       = end_byte;
		res.status     = ST_OK;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q   <= 1'b0;
			left_q   <= '0;
			phase_q  <= '0;
			key_q    <= '0;
			masked_q <= 1'b0;
		end else if (cmd.open_frame) begin
			open_q   <= (len != '0);
			left_q   <= len;
			phase_q  <= '0;
			key_q    <= key;
			masked_q <= masked;
		end else if (cmd.take_byte) begin
			phase_q <= phase_q + 2'd1;
			left_q  <= left_q - LEN_W'(1);
			if (end_byte) begin
				open_q <= 1'b0;
			end
		end
	end

endmodule

>>> rtl/core/websocket_frame_encoder.sv
// Channel  Handshake              Payload
// cmd      cmd_valid / cmd_stall  action, opcode, payload_length, mask_key, data_byte
// frm      frm_valid / frm_stall  out_byte, byte_valid, last_of_run, frame_end, status
// cfg      cfg_we                 cfg_wdata (mask_outgoing)
//
// A payload item yields one result; payload bytes stream at one per clock while frm_stall is low.
// A start item emits 2, 4 or 10 header bytes plus 4 key bytes when masking, one header byte
// per cycle from the header sequencer while frm_stall is low; a rejected one emits one status result.
// A result passes through the input register, then the result register.
// arst_n clears the control state and sets mask_outgoing; no clearing pass.
// A stalled result holds; the input register takes a new item in the same
// cycle the held item hands over its last result.
module websocket_frame_encoder (
	input  logic                        clk,
	input  logic                        arst_n,
	// configuration
	input  logic                        cfg_we,
	input  logic                        cfg_wdata,
	// command items
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  logic                        action,
	input  logic [3:0]                  opcode,
	input  logic [wsfe_pkg::LEN_W-1:0]  payload_length,
	input  logic [wsfe_pkg::KEY_W-1:0]  mask_key,
	input  logic [7:0]                  data_byte,
	// frame bytes
	output logic                        frm_valid,
	input  logic                        frm_stall,
	output logic [7:0]                  out_byte,
	output logic                        byte_valid,
	output logic                        last_of_run,
	output logic                        frame_end,
	output logic [1:0]                  status
);
	import wsfe_pkg::*;

	`include "websocket_frame_encoder_assert.svh"

	// config register: client side by default
	logic mask_outgoing_q;

	// input register stage
	logic             valid_s1;
	action_t          action_s1;
	logic [3:0]       opcode_s1;
	logic [LEN_W-1:0] len_s1;
	logic [KEY_W-1:0] key_s1;
	logic [7:0]       data_s1;

	// header byte counter
	logic [IDX_W-1:0] idx_q;

	// result register
	logic valid_s2;
	res_t res_s2;

	res_t       hdr_res;
	res_t       pay_res;
	res_t       res;
	logic       frame_open;
	logic       reject;
	logic       adv;
	logic       done;
	frame_cmd_t fcmd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_outgoing_q <= 1'b1;
		end else if (cfg_we) begin
			mask_outgoing_q <= cfg_wdata;
		end
	end

	wsfe_hdr u_hdr (
		.opcode (opcode_s1),
		.len    (len_s1),
		.key    (key_s1),
		.masked (mask_outgoing_q),
		.idx    (idx_q),
		.res    (hdr_res)
	);

	wsfe_frame u_frame (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (fcmd),
		.len        (len_s1),
		.key        (key_s1),
		.masked     (mask_outgoing_q),
		.data_byte  (data_s1),
		.frame_open (frame_open),
		.res        (pay_res)
	);

	// control frame with a payload over 125 bytes is refused outright
	assign reject = opcode_s1[3] && (len_s1 > LEN_MAX_SHORT);

	always_comb begin
		res = '{data: '0, byte_valid: 1'b0, last: 1'b1, fend: 1'b0, status: ST_OK};
		case (action_s1)
			ACT_START: begin
				if (reject) begin
					res.status = ST_CTRL_LONG;
				end else begin
					res = hdr_res;
				end
			end
			ACT_DATA: begin
				if (frame_open) begin
					res = pay_res;
				end else begin
					res.status = ST_NO_FRAME;
				end
			end
			default: begin
				res.status = ST_OK;
			end
		endcase
	end

	// one result moves into the result register whenever it is free or draining
	assign adv  = valid_s1 && (!valid_s2 || !frm_stall);
	assign done = adv && res.last;

	assign fcmd.open_frame = done && (action_s1 == ACT_START) && !reject;
	assign fcmd.take_byte  = adv && (action_s1 == ACT_DATA) && frame_open;

	assign cmd_stall = valid_s1 && !done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd_valid && !cmd_stall) begin
				valid_s1 <= 1'b1;
			end else if (done) begin
				valid_s1 <= 1'b0;
			end
			if (done) begin
				idx_q <= '0;
			end else if (adv) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (!frm_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && !cmd_stall) begin
			action_s1 <= action_t'(action);
			opcode_s1 <= opcode;
			len_s1    <= payload_length;
			key_s1    <= mask_key;
			data_s1   <= data_byte;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	assign frm_valid   = valid_s2;
	assign out_byte    = res_s2.data;
	assign byte_valid  = res_s2.byte_valid;
	assign last_of_run = res_s2.last;
	assign frame_end   = res_s2.fend;
	assign status      = res_s2.status;

	// a mid-header count only exists while a start item is held
	`WSFE_ASSERT_NOW(a_idx_start, clk, arst_n, idx_q != '0, valid_s1 && (action_s1 == ACT_START))
	// a flagged (non-byte) result always closes its run
	`WSFE_ASSERT_NOW(a_flag_last, clk, arst_n, frm_valid && !byte_valid, last_of_run)
	// the final frame byte is always the last result of its item
	`WSFE_ASSERT_NOW(a_end_last, clk, arst_n, frm_valid && frame_end, last_of_run && byte_valid)
	// once a run completes, the header counter restarts
	`WSFE_ASSERT_NEXT(a_idx_clear, clk, arst_n, done, idx_q == '0)

endmodule
